>>> sv/rsum_pkg.sv
// Shared widths, defaults and adder operation codes for the range-sum tree.
package rsum_pkg;

   localparam int POS_W = 10;
   localparam int VAL_W = 32;
   localparam int SUM_W = 42;
   localparam int DEFAULT_LEAVES = 1024;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 48;

   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   localparam logic OP_ASSIGN = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef logic [SUM_W-1:0] sum_type;

   function automatic sum_type sign_extend(input logic [VAL_W-1:0] v);
      sign_extend = {{(SUM_W - VAL_W){v[VAL_W-1]}}, v};
   endfunction

endpackage

>>> sv/rsum_alu.sv
// Shared adder/subtractor used for every tree sum and difference.
module rsum_alu (
   input  logic             op,
   input  rsum_pkg::sum_type a,
   input  rsum_pkg::sum_type b,
   output rsum_pkg::sum_type y
);

   always_comb begin
      case (op)
         rsum_pkg::ALU_ADD: y = a + b;
         rsum_pkg::ALU_SUB: y = a - b;
         default:           y = a + b;
      endcase
   end

endmodule

>>> sv/rsum_ram.sv
// Single-port node memory with registered read data.
module rsum_ram #(
   parameter int DEPTH = 2 * rsum_pkg::DEFAULT_LEAVES,
   parameter int WIDTH = rsum_pkg::SUM_W
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/range_sum_tree_point_assign.sv
// Range-sum tree with point assignment: sequencer around one node memory and one adder.
//
// The block holds LEAVES signed 32-bit values as the leaves of a bottom-up binary tree of
// 42-bit partial sums kept in one single-port memory of 2*LEAVES words. After reset a
// clearing pass writes zero to every node, one per cycle; req_tready stays low until it is
// done. An assignment (tuser 0) reads the old leaf, writes the new value to the leaf,
// then does a read and a write for each ancestor, all through the one memory port. A
// query (tuser 1) reads up to two nodes at each tree level, one for each end of the range,
// adds them to the total and shifts both ends up a level; it may wait for the rsp channel
// and returns one transfer on the rsp channel. Assignments to positions at or above
// LEAVES are dropped; a query range is clamped to the array and an empty range gives zero.
module range_sum_tree_point_assign #(
   parameter int LEAVES = rsum_pkg::DEFAULT_LEAVES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // position[9:0], new_value[41:10], range_low[51:42], range_high[61:52], zero fill
   input  logic [rsum_pkg::REQ_TDATA_W-1:0] req_tdata,
   // opcode[0]: 0 assigns, 1 queries
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // range_total[41:0], zero fill
   output logic [rsum_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int NODES  = 2 * LEAVES;
   localparam int NODE_W = $clog2(NODES);
   localparam int CNT_W  = $clog2(NODES + 1);
   localparam int POS_W  = rsum_pkg::POS_W;
   localparam int VAL_W  = rsum_pkg::VAL_W;
   localparam int SUM_W  = rsum_pkg::SUM_W;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_U_DIFF = 3'd2;
   localparam logic [2:0] S_U_RD   = 3'd3;
   localparam logic [2:0] S_U_WR   = 3'd4;
   localparam logic [2:0] S_Q_LOOP = 3'd5;
   localparam logic [2:0] S_Q_ACC  = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [CNT_W-1:0] l_ff, l_in;
   logic [CNT_W-1:0] r_ff, r_in;
   logic             side_ff, side_in;
   rsum_pkg::sum_type diff_ff, diff_in;
   rsum_pkg::sum_type total_ff, total_in;
   logic [VAL_W-1:0] new_ff, new_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   rsum_pkg::sum_type rsp_sum_ff, rsp_sum_in;

   logic [POS_W-1:0] in_pos, in_lo, in_hi;
   logic [VAL_W-1:0] in_val;
   logic             accept;
   logic             rsp_free;
   logic [CNT_W-1:0] r_dec;
   logic [NODE_W-1:0] node_up;
   int               lo_int, hi_int, pos_int;

   logic              mem_we, mem_re;
   logic [NODE_W-1:0] mem_addr;
   rsum_pkg::sum_type mem_wdata, mem_rdata;
   logic              alu_op;
   rsum_pkg::sum_type alu_a, alu_b, alu_y;

   assign in_pos = req_tdata[9:0];
   assign in_val = req_tdata[41:10];
   assign in_lo  = req_tdata[51:42];
   assign in_hi  = req_tdata[61:52];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign r_dec      = r_ff - 1'b1;
   assign node_up    = node_ff >> 1;

   assign pos_int = int'(in_pos);
   assign lo_int  = int'(in_lo);
   assign hi_int  = (int'(in_hi) >= LEAVES) ? (LEAVES - 1) : int'(in_hi);

   rsum_ram #(
      .DEPTH(NODES),
      .WIDTH(SUM_W)
   ) u_ram (
      .clock  (clock),
      .we     (mem_we),
      .re     (mem_re),
      .addr   (mem_addr),
      .wr_data(mem_wdata),
      .rd_data(mem_rdata)
   );

   rsum_alu u_alu (
      .op(alu_op),
      .a (alu_a),
      .b (alu_b),
      .y (alu_y)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      node_in       = node_ff;
      l_in          = l_ff;
      r_in          = r_ff;
      side_in       = side_ff;
      diff_in       = diff_ff;
      total_in      = total_ff;
      new_in        = new_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_sum_in    = rsp_sum_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = node_ff;
      mem_wdata     = alu_y;
      alu_op        = rsum_pkg::ALU_ADD;
      alu_a         = mem_rdata;
      alu_b         = total_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == NODE_W'(NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == rsum_pkg::OP_ASSIGN) begin
                  if (pos_int < LEAVES) begin
                     mem_re   = 1'b1;
                     mem_addr = NODE_W'(pos_int + LEAVES);
                     node_in  = NODE_W'(pos_int + LEAVES);
                     new_in   = in_val;
                     state_in = S_U_DIFF;
                  end
               end else begin
                  total_in = '0;
                  state_in = S_Q_LOOP;
                  if (lo_int >= LEAVES || lo_int > hi_int) begin
                     l_in = '0;
                     r_in = '0;
                  end else begin
                     l_in = CNT_W'(lo_int + LEAVES);
                     r_in = CNT_W'(hi_int + LEAVES + 1);
                  end
               end
            end
         end
         S_U_DIFF: begin
            // The leaf node holds the old value sign-extended, so it serves as the old value.
            alu_op    = rsum_pkg::ALU_SUB;
            alu_a     = rsum_pkg::sign_extend(new_ff);
            alu_b     = mem_rdata;
            diff_in   = alu_y;
            mem_we    = 1'b1;
            mem_wdata = rsum_pkg::sign_extend(new_ff);
            node_in   = node_up;
            state_in  = S_U_RD;
         end
         S_U_RD: begin
            mem_re   = 1'b1;
            state_in = S_U_WR;
         end
         S_U_WR: begin
            alu_b   = diff_ff;
            mem_we  = 1'b1;
            node_in = node_up;
            if (node_up == '0) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_U_RD;
            end
         end
         S_Q_LOOP: begin
            if (l_ff >= r_ff) begin
               if (rsp_free) begin
                  rsp_tvalid_in = 1'b1;
                  rsp_sum_in    = total_ff;
                  state_in      = S_IDLE;
               end
            end else if (l_ff[0]) begin
               mem_re   = 1'b1;
               mem_addr = l_ff[NODE_W-1:0];
               side_in  = 1'b0;
               state_in = S_Q_ACC;
            end else if (r_ff[0]) begin
               mem_re   = 1'b1;
               mem_addr = r_dec[NODE_W-1:0];
               r_in     = r_dec;
               side_in  = 1'b1;
               state_in = S_Q_ACC;
            end else begin
               l_in = l_ff >> 1;
               r_in = r_ff >> 1;
            end
         end
         S_Q_ACC: begin
            total_in = alu_y;
            if (!side_ff) begin
               l_in = l_ff + 1'b1;
            end
            state_in = S_Q_LOOP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff    <= node_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      side_ff    <= side_in;
      diff_ff    <= diff_in;
      total_ff   <= total_in;
      new_ff     <= new_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(rsum_pkg::RSP_TDATA_W - SUM_W){1'b0}}, rsp_sum_ff};

endmodule

>>> test/range_sum_checker.sv
// Checker for the range-sum tree: mirrors the array, predicts query totals and compares them.
`timescale 1ns / 1ps

package rsum_tb_pkg;

   typedef enum logic {
      REQ_ASSIGN = rsum_pkg::OP_ASSIGN,
      REQ_QUERY  = rsum_pkg::OP_QUERY
   } req_kind_type;

endpackage

module range_sum_checker #(
   parameter int LEAVES = rsum_pkg::DEFAULT_LEAVES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [rsum_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [rsum_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                               mismatches,
   output int                               open_queries
);

   localparam int POS_W = rsum_pkg::POS_W;
   localparam int VAL_W = rsum_pkg::VAL_W;
   localparam int SUM_W = rsum_pkg::SUM_W;

   logic signed [VAL_W-1:0] array_values [LEAVES];
   rsum_pkg::sum_type       totals_due [$];

   // Plain sum over the mirrored array; the range is clamped to the array like the block does.
   function automatic rsum_pkg::sum_type span_total(input logic [POS_W-1:0] lo,
                                                    input logic [POS_W-1:0] hi);
      longint      acc;
      int unsigned top_index;
      acc = 0;
      top_index = (hi >= LEAVES) ? LEAVES - 1 : hi;
      if (lo < LEAVES) begin
         for (int unsigned i = lo; i <= top_index; i++) begin
            acc += array_values[i];
         end
      end
      return acc[SUM_W-1:0];
   endfunction

   always @(posedge clock) begin
      rsum_pkg::sum_type seen;
      rsum_pkg::sum_type wanted;
      logic [POS_W-1:0]  pos;
      logic [VAL_W-1:0]  value;
      logic [POS_W-1:0]  lo;
      logic [POS_W-1:0]  hi;
      if (reset) begin
         foreach (array_values[i]) array_values[i] = '0;
         totals_due.delete();
         mismatches <= 0;
         open_queries <= 0;
      end else begin
         // A result always belongs to an earlier query, so it is matched before the new request.
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[SUM_W-1:0];
            if (totals_due.size() == 0) begin
               $display("%0t: rsp transfer with no query waiting, expected none, actual %0d",
                        $time, $signed(seen));
               mismatches <= mismatches + 1;
            end else begin
               wanted = totals_due.pop_front();
               if (seen !== wanted) begin
                  $display("%0t: range_total mismatch, expected %0d, actual %0d",
                           $time, $signed(wanted), $signed(seen));
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pos   = req_tdata[POS_W-1:0];
            value = req_tdata[POS_W +: VAL_W];
            lo    = req_tdata[POS_W+VAL_W +: POS_W];
            hi    = req_tdata[2*POS_W+VAL_W +: POS_W];
            if (rsum_tb_pkg::req_kind_type'(req_tuser) == rsum_tb_pkg::REQ_ASSIGN) begin
               if (pos < LEAVES) array_values[pos] = value;
            end else begin
               totals_due = {totals_due, span_total(lo, hi)};
            end
         end
         open_queries <= totals_due.size();
      end
   end

endmodule

>>> test/tb.sv
// Testbench top for range_sum_tree_point_assign: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb;

   localparam int               POS_W    = rsum_pkg::POS_W;
   localparam int               VAL_W    = rsum_pkg::VAL_W;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(rsum_pkg::DEFAULT_LEAVES - 1);
   localparam logic [VAL_W-1:0] VAL_MAX  = 32'h7fff_ffff;
   localparam logic [VAL_W-1:0] VAL_MIN  = 32'h8000_0000;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic [rsum_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                             req_tuser  = 1'b0;
   logic                             rsp_tready = 1'b0;
   wire                              req_tready;
   wire                              rsp_tvalid;
   wire  [rsum_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   int                               mismatches;
   int                               open_queries;
   bit                               no_gaps    = 1'b0;

   always #6 clock = ~clock;

   range_sum_tree_point_assign i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   range_sum_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .mismatches   (mismatches),
      .open_queries (open_queries)
   );

   function automatic int unsigned idle_cycles();
      return no_gaps ? 0 : $urandom_range(0, 15);
   endfunction

   // Valid stays high into the next item when no gap is drawn.
   task automatic send(input rsum_tb_pkg::req_kind_type kind, input logic [POS_W-1:0] pos,
                       input logic [VAL_W-1:0] value, input logic [POS_W-1:0] lo,
                       input logic [POS_W-1:0] hi);
      int unsigned gap;
      gap = idle_cycles();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, hi, lo, value, pos};
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   // The unused range fields carry random bits.
   task automatic put_value(input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] value);
      send(rsum_tb_pkg::REQ_ASSIGN, pos, value, POS_W'($urandom), POS_W'($urandom));
   endtask

   // The unused position and value fields carry random bits.
   task automatic ask_total(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
      send(rsum_tb_pkg::REQ_QUERY, POS_W'($urandom), VAL_W'($urandom), lo, hi);
   endtask

   // Result side: a stall is drawn before each transfer; ready is not dropped when it is zero.
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      stall = idle_cycles();
      forever begin
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         stall = idle_cycles();
      end
   end

   initial begin
      #8_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int unsigned      a;
      int unsigned      b;
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      pos;
      int               lean;
      logic [VAL_W-1:0] value;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty tree, extreme values at both ends, overwrites and empty ranges.
      ask_total(0, LAST_POS);
      put_value(0, VAL_MAX);
      put_value(LAST_POS, VAL_MIN);
      put_value(512, '1);
      ask_total(0, LAST_POS);
      ask_total(0, 0);
      ask_total(LAST_POS, LAST_POS);
      ask_total(LAST_POS, 0);
      ask_total(5, 4);
      put_value(0, VAL_MIN);
      ask_total(0, 511);
      ask_total(0, 512);
      put_value(1, VAL_MAX);
      ask_total(0, 1);
      put_value(LAST_POS, '0);
      ask_total(512, LAST_POS);
      send(rsum_tb_pkg::REQ_QUERY, '1, '1, 1, POS_W'(LAST_POS - 1));
      send(rsum_tb_pkg::REQ_ASSIGN, 2, VAL_MAX, '1, '1);
      send(rsum_tb_pkg::REQ_QUERY, '0, '0, '0, '1);
      ask_total(1, 2);

      for (int i = 0; i < 1600; i++) begin
         if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         // Two stretches lean on one extreme so that totals reach the top bits of the sum.
         if (i >= 400 && i < 800) lean = 1;
         else if (i >= 800 && i < 1200) lean = 2;
         else lean = 0;
         if ($urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 15) == 0) pos = $urandom_range(0, 1) ? LAST_POS : 0;
            else pos = $urandom_range(0, LAST_POS);
            case ($urandom_range(0, 7))
               0: value = VAL_MAX;
               1: value = VAL_MIN;
               2: value = '0;
               3: value = '1;
               default: value = $urandom;
            endcase
            if (lean != 0 && $urandom_range(0, 3) != 0) value = (lean == 1) ? VAL_MAX : VAL_MIN;
            put_value(POS_W'(pos), value);
         end else begin
            a = $urandom_range(0, LAST_POS);
            b = $urandom_range(0, LAST_POS);
            case ($urandom_range(0, 7))
               0: begin
                  lo = a;
                  hi = b;
               end
               1: begin
                  lo = 0;
                  hi = b;
               end
               2: begin
                  lo = a;
                  hi = LAST_POS;
               end
               3, 4: begin
                  lo = a;
                  hi = a + $urandom_range(0, 15);
                  if (hi > LAST_POS) hi = LAST_POS;
               end
               default: begin
                  lo = (a < b) ? a : b;
                  hi = (a < b) ? b : a;
               end
            endcase
            ask_total(POS_W'(lo), POS_W'(hi));
         end
      end
      req_tvalid <= 1'b0;
      no_gaps = 1'b0;

      @(posedge clock);
      while (open_queries != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatches == 0 && open_queries == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/rsum_pkg.sv
sv/rsum_alu.sv
sv/rsum_ram.sv
sv/range_sum_tree_point_assign.sv
test/range_sum_checker.sv
test/tb.sv
